>>> rtl/core/pbvc_pkg.sv
// Package for the point batch view transform and cull block.
// Holds field widths, register reset values, register indexes and the stage enable type.
// No dependencies.
`default_nettype none

package pbvc_pkg;

   // Field widths.
   localparam int POS_W    = 48;
   localparam int DIFF_W   = 49;
   localparam int SCALE_W  = 32;
   localparam int OFF_W    = 32;
   localparam int SCR_W    = 32;
   localparam int SIZE_W   = 16;
   localparam int PHI_W    = 50;
   localparam int PLO_W    = 64;
   localparam int IPART_W  = 52;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 48;

   // Register reset values.
   localparam logic [SCALE_W-1:0] SCALE_RESET = 32'h0001_0000;

   // Configuration register indexes.
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_VIEW_LEFT     = 3'd0,
      CSR_VIEW_TOP      = 3'd1,
      CSR_X_SCALE       = 3'd2,
      CSR_Y_SCALE       = 3'd3,
      CSR_OFFSET_X      = 3'd4,
      CSR_OFFSET_Y      = 3'd5,
      CSR_SCREEN_WIDTH  = 3'd6,
      CSR_SCREEN_HEIGHT = 3'd7
   } csr_index_type;

   // Load enables of the datapath stages, one per register stage.
   typedef struct packed {
      logic diff;
      logic prod;
      logic sum;
      logic round;
   } stage_en_type;

endpackage

`default_nettype wire

>>> rtl/core/pbvc_axis.sv
// One axis of the view transform: origin subtract, split multiply, offset add,
// rounding and saturation, four register stages. Depends on pbvc_pkg.
`default_nettype none

module pbvc_axis (
   input  wire                                   clock,
   input  wire pbvc_pkg::stage_en_type           en,
   input  wire signed [pbvc_pkg::POS_W-1:0]      pos,
   input  wire signed [pbvc_pkg::POS_W-1:0]      origin,
   input  wire        [pbvc_pkg::SCALE_W-1:0]    scale,
   input  wire signed [pbvc_pkg::OFF_W-1:0]      offset,
   output logic signed [pbvc_pkg::SCR_W-1:0]     screen
);

   logic signed [pbvc_pkg::DIFF_W-1:0]  diff_ff, diff_in;
   logic        [pbvc_pkg::PLO_W-1:0]   plo_ff, plo_in;
   logic signed [pbvc_pkg::PHI_W-1:0]   phi_ff, phi_in;
   logic signed [pbvc_pkg::IPART_W-1:0] ipart_ff, ipart_in;
   logic                                frac_ge_ff, frac_ge_in;
   logic                                frac_gt_ff, frac_gt_in;
   logic signed [pbvc_pkg::SCR_W-1:0]   screen_ff, screen_in;
   logic        [pbvc_pkg::DIFF_W-33:0] diff_hi;
   logic signed [pbvc_pkg::IPART_W-1:0] rounded;
   logic                                round_up;

   // Difference to the view origin, exact in one extra bit.
   always_comb begin
      diff_in = $signed({pos[pbvc_pkg::POS_W-1], pos})
              - $signed({origin[pbvc_pkg::POS_W-1], origin});
   end

   // Split product: the low 32 bits of the difference unsigned, the top bits signed.
   always_comb begin
      diff_hi = diff_ff[pbvc_pkg::DIFF_W-1:32];
      plo_in  = {32'b0, diff_ff[31:0]} * {32'b0, scale};
      phi_in  = $signed({{(pbvc_pkg::PHI_W-(pbvc_pkg::DIFF_W-32)){diff_hi[pbvc_pkg::DIFF_W-33]}},
                         diff_hi})
              * $signed({{(pbvc_pkg::PHI_W-pbvc_pkg::SCALE_W){1'b0}}, scale});
   end

   // Integer part of the product floored, plus the pixel offset; fraction flags.
   always_comb begin
      ipart_in = $signed({{(pbvc_pkg::IPART_W-pbvc_pkg::PHI_W){phi_ff[pbvc_pkg::PHI_W-1]}},
                          phi_ff})
               + $signed({{(pbvc_pkg::IPART_W-32){1'b0}}, plo_ff[63:32]})
               + $signed({{(pbvc_pkg::IPART_W-pbvc_pkg::OFF_W){offset[pbvc_pkg::OFF_W-1]}},
                          offset});
      frac_ge_in = plo_ff[31];
      frac_gt_in = plo_ff[31] & (|plo_ff[30:0]);
   end

   // Round to nearest with ties away from zero, then saturate to 32 bits.
   always_comb begin
      round_up = ipart_ff[pbvc_pkg::IPART_W-1] ? frac_gt_ff : frac_ge_ff;
      rounded  = ipart_ff + $signed({{(pbvc_pkg::IPART_W-1){1'b0}}, round_up});
      priority if (!rounded[pbvc_pkg::IPART_W-1] &&
                   (|rounded[pbvc_pkg::IPART_W-2:pbvc_pkg::SCR_W-1])) begin
         screen_in = {1'b0, {(pbvc_pkg::SCR_W-1){1'b1}}};
      end else if (rounded[pbvc_pkg::IPART_W-1] &&
                   !(&rounded[pbvc_pkg::IPART_W-2:pbvc_pkg::SCR_W-1])) begin
         screen_in = {1'b1, {(pbvc_pkg::SCR_W-1){1'b0}}};
      end else begin
         screen_in = rounded[pbvc_pkg::SCR_W-1:0];
      end
   end

   // Stage registers, each loaded when its stage moves.
   always_ff @(posedge clock) begin
      if (en.diff) begin
         diff_ff <= diff_in;
      end
      if (en.prod) begin
         plo_ff <= plo_in;
         phi_ff <= phi_in;
      end
      if (en.sum) begin
         ipart_ff   <= ipart_in;
         frac_ge_ff <= frac_ge_in;
         frac_gt_ff <= frac_gt_in;
      end
      if (en.round) begin
         screen_ff <= screen_in;
      end
   end

   assign screen = screen_ff;

endmodule

`default_nettype wire

>>> rtl/core/pbvc_bbox.sv
// Batch bounding box, visibility test and the result register.
// Depends on pbvc_pkg.
`default_nettype none

module pbvc_bbox (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  load,
   input  wire                                  item,
   input  wire signed [pbvc_pkg::SCR_W-1:0]     sx,
   input  wire signed [pbvc_pkg::SCR_W-1:0]     sy,
   input  wire                                  last,
   input  wire        [pbvc_pkg::SIZE_W-1:0]    width,
   input  wire        [pbvc_pkg::SIZE_W-1:0]    height,
   output logic signed [pbvc_pkg::SCR_W-1:0]    screen_x,
   output logic signed [pbvc_pkg::SCR_W-1:0]    screen_y,
   output logic                                 batch_end,
   output logic                                 visible
);

   logic signed [pbvc_pkg::SCR_W-1:0] min_x_ff, max_x_ff, min_y_ff, max_y_ff;
   logic signed [pbvc_pkg::SCR_W-1:0] min_x_in, max_x_in, min_y_in, max_y_in;
   logic                              first_ff, first_in;
   logic signed [pbvc_pkg::SCR_W-1:0] screen_x_ff, screen_y_ff;
   logic                              batch_end_ff, visible_ff, visible_in;
   logic signed [pbvc_pkg::SCR_W-1:0] width_s, height_s;
   logic                              max_x_ok, min_x_ok, max_y_ok, min_y_ok;

   // Box update; the first point of a batch starts a new box.
   always_comb begin
      if (first_ff) begin
         min_x_in = sx;
         max_x_in = sx;
         min_y_in = sy;
         max_y_in = sy;
      end else begin
         min_x_in = (sx < min_x_ff) ? sx : min_x_ff;
         max_x_in = (sx > max_x_ff) ? sx : max_x_ff;
         min_y_in = (sy < min_y_ff) ? sy : min_y_ff;
         max_y_in = (sy > max_y_ff) ? sy : max_y_ff;
      end
      first_in = last;
   end

   // Overlap test on the updated box, compared point and box in parallel.
   always_comb begin
      width_s  = $signed({{(pbvc_pkg::SCR_W-pbvc_pkg::SIZE_W){1'b0}}, width});
      height_s = $signed({{(pbvc_pkg::SCR_W-pbvc_pkg::SIZE_W){1'b0}}, height});
      max_x_ok = !sx[pbvc_pkg::SCR_W-1] || (!first_ff && !max_x_ff[pbvc_pkg::SCR_W-1]);
      max_y_ok = !sy[pbvc_pkg::SCR_W-1] || (!first_ff && !max_y_ff[pbvc_pkg::SCR_W-1]);
      min_x_ok = (sx < width_s) || (!first_ff && (min_x_ff < width_s));
      min_y_ok = (sy < height_s) || (!first_ff && (min_y_ff < height_s));
      visible_in = last && max_x_ok && min_x_ok && max_y_ok && min_y_ok;
   end

   // Box state moves only with a real transaction.
   always_ff @(posedge clock) begin
      if (reset) begin
         first_ff <= 1'b1;
         min_x_ff <= '0;
         max_x_ff <= '0;
         min_y_ff <= '0;
         max_y_ff <= '0;
      end else if (load && item) begin
         first_ff <= first_in;
         min_x_ff <= min_x_in;
         max_x_ff <= max_x_in;
         min_y_ff <= min_y_in;
         max_y_ff <= max_y_in;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (load) begin
         screen_x_ff  <= sx;
         screen_y_ff  <= sy;
         batch_end_ff <= last;
         visible_ff   <= visible_in;
      end
   end

   assign screen_x  = screen_x_ff;
   assign screen_y  = screen_y_ff;
   assign batch_end = batch_end_ff;
   assign visible   = visible_ff;

endmodule

`default_nettype wire

>>> rtl/core/point_batch_view_transform_cull_top.sv
// Top level of the point batch view transform and cull block: configuration
// registers, stage control and the two axis datapaths. Depends on pbvc_pkg,
// pbvc_axis and pbvc_bbox.
//
//   Channel   Direction  Handshake            Payload
//   req_      in         req_valid/req_stall  x_pos, y_pos, last_point
//   rsp_      out        rsp_valid/rsp_stall  screen_x, screen_y, batch_end, visible
//   csr_      in         csr_valid/csr_ready  csr_index, csr_wdata
//
// One transaction per cycle is taken while req_stall is low; a result is
// presented after its transaction has passed the five registers: origin subtract,
// split multiply, offset add, round and saturate, then the box update into the
// result register. Each stage moves when the one after it is empty or moving, so
// bubbles close up and new transactions are taken while a result waits on
// rsp_stall, until the stages behind it are full.
// Reset clears the stage valid bits, the box and restores register defaults.
// csr_ready is always high.
`default_nettype none

module point_batch_view_transform_cull_top (
   input  wire                                    clock,
   input  wire                                    reset,
   input  wire                                    req_valid,
   output logic                                   req_stall,
   input  wire signed [pbvc_pkg::POS_W-1:0]       req_x_pos,
   input  wire signed [pbvc_pkg::POS_W-1:0]       req_y_pos,
   input  wire                                    req_last_point,
   output logic                                   rsp_valid,
   input  wire                                    rsp_stall,
   output logic signed [pbvc_pkg::SCR_W-1:0]      rsp_screen_x,
   output logic signed [pbvc_pkg::SCR_W-1:0]      rsp_screen_y,
   output logic                                   rsp_batch_end,
   output logic                                   rsp_visible,
   input  wire                                    csr_valid,
   output logic                                   csr_ready,
   input  wire        [pbvc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire        [pbvc_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   logic signed [pbvc_pkg::POS_W-1:0]   view_left_ff, view_top_ff;
   logic        [pbvc_pkg::SCALE_W-1:0] x_scale_ff, y_scale_ff;
   logic signed [pbvc_pkg::OFF_W-1:0]   offset_x_ff, offset_y_ff;
   logic        [pbvc_pkg::SIZE_W-1:0]  screen_width_ff, screen_height_ff;

   logic                   v_a_ff, v_b_ff, v_c_ff, v_d_ff, v_o_ff;
   logic                   last_a_ff, last_b_ff, last_c_ff, last_d_ff;
   logic                   ready_a, ready_b, ready_c, ready_d, ready_o;
   pbvc_pkg::stage_en_type en;
   logic signed [pbvc_pkg::SCR_W-1:0] sx, sy;

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         view_left_ff     <= '0;
         view_top_ff      <= '0;
         x_scale_ff       <= pbvc_pkg::SCALE_RESET;
         y_scale_ff       <= pbvc_pkg::SCALE_RESET;
         offset_x_ff      <= '0;
         offset_y_ff      <= '0;
         screen_width_ff  <= '0;
         screen_height_ff <= '0;
      end else if (csr_valid) begin
         unique case (pbvc_pkg::csr_index_type'(csr_index))
            pbvc_pkg::CSR_VIEW_LEFT: begin
               view_left_ff <= csr_wdata[pbvc_pkg::POS_W-1:0];
            end
            pbvc_pkg::CSR_VIEW_TOP: begin
               view_top_ff <= csr_wdata[pbvc_pkg::POS_W-1:0];
            end
            pbvc_pkg::CSR_X_SCALE: begin
               x_scale_ff <= csr_wdata[pbvc_pkg::SCALE_W-1:0];
            end
            pbvc_pkg::CSR_Y_SCALE: begin
               y_scale_ff <= csr_wdata[pbvc_pkg::SCALE_W-1:0];
            end
            pbvc_pkg::CSR_OFFSET_X: begin
               offset_x_ff <= csr_wdata[pbvc_pkg::OFF_W-1:0];
            end
            pbvc_pkg::CSR_OFFSET_Y: begin
               offset_y_ff <= csr_wdata[pbvc_pkg::OFF_W-1:0];
            end
            pbvc_pkg::CSR_SCREEN_WIDTH: begin
               screen_width_ff <= csr_wdata[pbvc_pkg::SIZE_W-1:0];
            end
            pbvc_pkg::CSR_SCREEN_HEIGHT: begin
               screen_height_ff <= csr_wdata[pbvc_pkg::SIZE_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   assign csr_ready = 1'b1;

   // A stage may load when it is empty or its content moves on.
   always_comb begin
      ready_o  = !v_o_ff || !rsp_stall;
      ready_d  = !v_d_ff || ready_o;
      ready_c  = !v_c_ff || ready_d;
      ready_b  = !v_b_ff || ready_c;
      ready_a  = !v_a_ff || ready_b;
      en.diff  = ready_a;
      en.prod  = ready_b;
      en.sum   = ready_c;
      en.round = ready_d;
   end

   assign req_stall = !ready_a;

   // Stage valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         v_a_ff <= 1'b0;
         v_b_ff <= 1'b0;
         v_c_ff <= 1'b0;
         v_d_ff <= 1'b0;
         v_o_ff <= 1'b0;
      end else begin
         if (ready_a) v_a_ff <= req_valid;
         if (ready_b) v_b_ff <= v_a_ff;
         if (ready_c) v_c_ff <= v_b_ff;
         if (ready_d) v_d_ff <= v_c_ff;
         if (ready_o) v_o_ff <= v_d_ff;
      end
   end

   // Batch end marker travels alongside the datapath.
   always_ff @(posedge clock) begin
      if (ready_a) last_a_ff <= req_last_point;
      if (ready_b) last_b_ff <= last_a_ff;
      if (ready_c) last_c_ff <= last_b_ff;
      if (ready_d) last_d_ff <= last_c_ff;
   end

   // Horizontal and vertical datapaths.
   pbvc_axis u_axis_x (
      .clock  (clock),
      .en     (en),
      .pos    (req_x_pos),
      .origin (view_left_ff),
      .scale  (x_scale_ff),
      .offset (offset_x_ff),
      .screen (sx)
   );

   pbvc_axis u_axis_y (
      .clock  (clock),
      .en     (en),
      .pos    (req_y_pos),
      .origin (view_top_ff),
      .scale  (y_scale_ff),
      .offset (offset_y_ff),
      .screen (sy)
   );

   // Bounding box and result register.
   pbvc_bbox u_bbox (
      .clock     (clock),
      .reset     (reset),
      .load      (ready_o),
      .item      (v_d_ff),
      .sx        (sx),
      .sy        (sy),
      .last      (last_d_ff),
      .width     (screen_width_ff),
      .height    (screen_height_ff),
      .screen_x  (rsp_screen_x),
      .screen_y  (rsp_screen_y),
      .batch_end (rsp_batch_end),
      .visible   (rsp_visible)
   );

   assign rsp_valid = v_o_ff;

endmodule

`default_nettype wire
